### rtl/core/wpjs_pkg.sv
// wpjs_pkg: shared types, codes and defaults of the weighted priority job scheduler
// no dependencies; used by every module under rtl/core
`default_nettype none

package wpjs_pkg;

  localparam int NUM_LEVELS_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_WORKERS_DEF = 4;

  // widths that cover the largest allowed configuration
  localparam int LEVEL_W = 3;
  localparam int ENTRY_W = 6;

  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_FETCH = 2'd1;
  localparam logic [1:0] ACT_REQ   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_STOP  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] job_id;
    logic [3:0] priority_req;
    logic [1:0] worker_id;
  } item_t;

  typedef struct packed {
    logic [7:0] granted_job;
    logic       granted;
    logic [1:0] status;
    logic [1:0] placed_level;
  } result_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [LEVEL_W-1:0] level;
    logic [7:0]         job;
  } bank_op_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] prev_level;
  } scan_t;

  // level named by one entry of the sequence 0 | 0,1 | 0,1,2 | ...
  function automatic int seq_level(int idx, int n);
    int rem;
    int res;
    bit hit;
    rem = idx;
    res = 0;
    hit = 1'b0;
    for (int run = 1; run <= n; run++) begin
      if (!hit) begin
        if (rem < run) begin
          res = rem;
          hit = 1'b1;
        end else begin
          rem = rem - run;
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/wpjs_seq_scan.sv
// wpjs_seq_scan: lookup over the weighted level sequence from a worker cursor
// depends on wpjs_pkg (scan_t, seq_level)
`default_nettype none

module wpjs_seq_scan #(
  parameter int NUM_LEVELS = wpjs_pkg::NUM_LEVELS_DEF
) (
  input  wire logic [((NUM_LEVELS*(NUM_LEVELS+1))/2 > 1 ?
                      $clog2((NUM_LEVELS*(NUM_LEVELS+1))/2) : 1)-1:0] cursor,
  input  wire logic [NUM_LEVELS-1:0] nonempty,
  output wpjs_pkg::scan_t            scan
);

  localparam int SEQ_LEN = (NUM_LEVELS * (NUM_LEVELS + 1)) / 2;
  localparam int SW      = SEQ_LEN > 1 ? $clog2(SEQ_LEN) : 1;
  localparam int LW      = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;

  logic [LW-1:0]      lvl_tab [SEQ_LEN];
  logic [SEQ_LEN-1:0] hit;
  logic [SW-1:0]      first_ge;
  logic               found_ge;
  logic [SW-1:0]      first_any;
  logic [SW-1:0]      entry;
  logic [SW-1:0]      prev;

  for (genvar e = 0; e < SEQ_LEN; e++) begin : g_tab
    assign lvl_tab[e] = LW'(wpjs_pkg::seq_level(e, NUM_LEVELS));
    assign hit[e]     = nonempty[lvl_tab[e]];
  end

  // first non-empty entry at or after the cursor, else first one from the start
  always_comb begin
    first_ge  = '0;
    found_ge  = 1'b0;
    first_any = '0;
    for (int e = SEQ_LEN - 1; e >= 0; e--) begin
      if (hit[e]) begin
        first_any = SW'(e);
        if (SW'(e) >= cursor) begin
          first_ge = SW'(e);
          found_ge = 1'b1;
        end
      end
    end
  end

  assign entry = found_ge ? first_ge : first_any;
  assign prev  = (cursor == '0) ? SW'(SEQ_LEN - 1) : cursor - SW'(1);

  always_comb begin
    scan            = '0;
    scan.entry      = wpjs_pkg::ENTRY_W'(entry);
    scan.level      = wpjs_pkg::LEVEL_W'(lvl_tab[entry]);
    scan.prev_level = wpjs_pkg::LEVEL_W'(lvl_tab[prev]);
  end

endmodule

`default_nettype wire

### rtl/core/wpjs_fifo_bank.sv
// wpjs_fifo_bank: per-level job fifos in one shared memory, heads and counts in flops
// depends on wpjs_pkg (bank_op_t)
`default_nettype none

module wpjs_fifo_bank #(
  parameter int NUM_LEVELS  = wpjs_pkg::NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH = wpjs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wpjs_pkg::bank_op_t op,
  output logic [NUM_LEVELS-1:0]   nonempty,
  output logic [NUM_LEVELS-1:0]   full,
  output logic [7:0]              rdata
);

  localparam int LW   = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
  localparam int HW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = HW + 2;

  logic [7:0]    mem [NUM_LEVELS * (1 << HW)];
  logic [HW-1:0] head  [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];

  logic [LW-1:0]   lvl;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] wrapped;
  logic [HW-1:0]   tail;
  logic [HW-1:0]   head_inc;
  logic            do_push;

  assign lvl = op.level[LW-1:0];

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_flag
    assign nonempty[l] = count[l] != '0;
    assign full[l]     = count[l] == CW'(QUEUE_DEPTH);
  end

  // tail is head plus count wrapped once round the ring
  assign sum      = {{(SUMW-HW){1'b0}}, head[lvl]} + {{(SUMW-CW){1'b0}}, count[lvl]};
  assign wrapped  = (sum >= SUMW'(QUEUE_DEPTH)) ? sum - SUMW'(QUEUE_DEPTH) : sum;
  assign tail     = wrapped[HW-1:0];
  assign head_inc = (head[lvl] == HW'(QUEUE_DEPTH - 1)) ? '0 : head[lvl] + HW'(1);
  assign do_push  = op.push && !full[lvl];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[{lvl, tail}] <= op.job;
    end
    if (op.pop) begin
      rdata <= mem[{lvl, head[lvl]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
    end else if (do_push) begin
      count[lvl] <= count[lvl] + CW'(1);
    end else if (op.pop) begin
      head[lvl]  <= head_inc;
      count[lvl] <= count[lvl] - CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/weighted_priority_job_scheduler.sv
// weighted_priority_job_scheduler: top level, command sequencer and worker cursor memory
// depends on wpjs_pkg, wpjs_seq_scan, wpjs_fifo_bank
//
//   channel   handshake                  payload
//   command   start, busy                item   (wpjs_pkg::item_t)
//   result    done (one-cycle strobe)    result (wpjs_pkg::result_t)
//   config    cfg_write                  cfg_data (run enable)
//
// one command at a time: enqueue, requeue and fetches that return no job finish after the look
// state; a granted fetch also passes the grant state, as the cursor memory read is
// followed by the job memory read.
// result is shown on done in the cycle after the last step; the receiver cannot stall it.
// synchronous reset clears heads, counts and cursor valid bits at once, no clearing pass;
// the job memory is not cleared.
`default_nettype none

module weighted_priority_job_scheduler #(
  parameter int NUM_LEVELS  = wpjs_pkg::NUM_LEVELS_DEF,
  parameter int QUEUE_DEPTH = wpjs_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_WORKERS = wpjs_pkg::NUM_WORKERS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire wpjs_pkg::item_t   item,
  output logic                   done,
  output wpjs_pkg::result_t      result,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data
);

  localparam int SEQ_LEN = (NUM_LEVELS * (NUM_LEVELS + 1)) / 2;
  localparam int SW      = SEQ_LEN > 1 ? $clog2(SEQ_LEN) : 1;
  localparam int LW      = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
  localparam int WW      = NUM_WORKERS > 1 ? $clog2(NUM_WORKERS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_GRANT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  wpjs_pkg::item_t       req;
  logic [WW-1:0]         wsel;
  logic                  run_en;
  logic                  accept;

  logic [SW-1:0]          cur_mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] cur_valid;
  logic [SW-1:0]          cur_rd;
  logic                   cur_rd_valid;
  logic [SW-1:0]          cursor;
  logic                   cur_we;

  logic [4:0]            w5;
  logic [4:0]            wsel5;
  logic [WW-1:0]         wsel_in;

  wpjs_pkg::scan_t       scan;
  wpjs_pkg::bank_op_t    op;
  wpjs_pkg::result_t     res_next;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] full;
  logic [7:0]            rdata;
  logic                  grant;

  logic [LW-1:0]         enq_lvl;
  logic [LW-1:0]         prev_lvl;
  logic [LW-1:0]         rq_lvl;
  logic [LW-1:0]         lvl_sel;
  logic [7:0]            lvl_ext;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  // worker id taken modulo the worker count; the id is below twice any count above one
  assign w5 = {3'b000, item.worker_id};
  always_comb begin
    if (NUM_WORKERS == 1) begin
      wsel5 = '0;
    end else if (w5 >= 5'(NUM_WORKERS)) begin
      wsel5 = w5 - 5'(NUM_WORKERS);
    end else begin
      wsel5 = w5;
    end
  end
  assign wsel_in = wsel5[WW-1:0];

  // cursor memory: one registered read at transfer, written back on a granted fetch
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[wsel] <= scan.entry[SW-1:0];
    end
    if (accept) begin
      cur_rd <= cur_mem[wsel_in];
      req    <= item;
      wsel   <= wsel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= '0;
      cur_rd_valid <= 1'b0;
    end else begin
      if (cur_we) begin
        cur_valid[wsel] <= 1'b1;
      end
      if (accept) begin
        cur_rd_valid <= cur_valid[wsel_in];
      end
    end
  end

  assign cursor = cur_rd_valid ? cur_rd : '0;

  wpjs_seq_scan #(
    .NUM_LEVELS(NUM_LEVELS)
  ) u_scan (
    .cursor  (cursor),
    .nonempty(nonempty),
    .scan    (scan)
  );

  wpjs_fifo_bank #(
    .NUM_LEVELS (NUM_LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .nonempty(nonempty),
    .full    (full),
    .rdata   (rdata)
  );

  assign enq_lvl  = (req.priority_req > 4'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1)
                                                            : req.priority_req[LW-1:0];
  assign prev_lvl = scan.prev_level[LW-1:0];
  assign rq_lvl   = (prev_lvl >= LW'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1)
                                                      : prev_lvl + LW'(1);

  always_comb begin
    lvl_sel  = '0;
    lvl_ext  = '0;
    op       = '0;
    cur_we   = 1'b0;
    grant    = 1'b0;
    res_next = '0;
    if (state == ST_LOOK) begin
      unique case (req.action)
        wpjs_pkg::ACT_ENQ: begin
          lvl_sel         = enq_lvl;
          op.push         = 1'b1;
          res_next.status = full[enq_lvl] ? wpjs_pkg::STAT_FULL : wpjs_pkg::STAT_OK;
        end
        wpjs_pkg::ACT_FETCH: begin
          priority if (!run_en) begin
            res_next.status = wpjs_pkg::STAT_STOP;
          end else if (nonempty == '0) begin
            res_next.status = wpjs_pkg::STAT_EMPTY;
          end else begin
            lvl_sel          = scan.level[LW-1:0];
            op.pop           = 1'b1;
            cur_we           = 1'b1;
            grant            = 1'b1;
            res_next.granted = 1'b1;
            res_next.status  = wpjs_pkg::STAT_OK;
          end
        end
        wpjs_pkg::ACT_REQ: begin
          lvl_sel         = rq_lvl;
          op.push         = 1'b1;
          res_next.status = full[rq_lvl] ? wpjs_pkg::STAT_FULL : wpjs_pkg::STAT_OK;
        end
        wpjs_pkg::ACT_NONE: begin
          res_next = '0;
        end
      endcase
      lvl_ext               = {{(8-LW){1'b0}}, lvl_sel};
      op.level              = wpjs_pkg::LEVEL_W'(lvl_sel);
      op.job                = req.job_id;
      res_next.placed_level = lvl_ext[1:0];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:  state_next = accept ? ST_LOOK : ST_IDLE;
      ST_LOOK:  state_next = grant ? ST_GRANT : ST_IDLE;
      ST_GRANT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      run_en <= 1'b1;
    end else begin
      state <= state_next;
      done  <= (state == ST_LOOK && !grant) || state == ST_GRANT;
      if (cfg_write) begin
        run_en <= cfg_data;
      end
    end
  end

  // payload: job id of a granted fetch lands in the cycle after the other fields
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      result <= res_next;
    end else if (state == ST_GRANT) begin
      result.granted_job <= rdata;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_LOOK || $past(state) == ST_GRANT)
    else $error("result strobe without a finishing step");

  a_no_job_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.granted |-> result.granted_job == 8'd0)
    else $error("job id on a result that granted nothing");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.granted |-> result.status == wpjs_pkg::STAT_OK)
    else $error("granted fetch with a non-ok status");
`endif

endmodule

`default_nettype wire
